>>> src/pbfb_pkg.sv
// Shared types and constants for the parallel handshake frame bridge.
package pbfb_pkg;

    localparam logic [7:0] TERMINATOR = 8'h3B;

    typedef struct packed {
        logic       host_valid;
        logic [7:0] host_byte;
        logic       partner_ready;
        logic       partner_avail;
        logic [7:0] bus_sample;
        logic       tx_ready;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] pkt_byte;
        logic       last;
        logic       host_taken;
        logic       udav_line;
        logic       creq_line;
        logic       drive_enable;
        logic [7:0] bus_drive;
    } result_t;

    typedef enum logic [1:0] {
        SEND_IDLE    = 2'd0,
        SEND_YIELDED = 2'd1,
        SEND_READY   = 2'd2,
        SEND_DRIVING = 2'd3
    } send_state_t;

    typedef enum logic [1:0] {
        CTRL_IDLE   = 2'd0,
        CTRL_READ   = 2'd1,
        CTRL_BYTE   = 2'd2,
        CTRL_STATUS = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic in_ready;
        logic ld_byte;
        logic ld_status;
    } cmd_t;

    typedef struct packed {
        logic flush_any;
        logic out_free;
        logic idx_last;
    } stat_t;

endpackage

>>> src/parallel_handshake_frame_bridge.sv
// Top level of the parallel handshake frame bridge.
//
// One request on the item channel is one tick of sampled partner pins plus an
// optional host byte offer. For each request the block returns zero or more
// packet byte results followed by one status result that carries last = 1 and
// the pin levels to drive toward the partner after the tick.
// A request that causes no flush loads its status result into the output
// register at acceptance, so such requests can follow back to back while the
// receiver does not stall. A request that flushes N buffered bytes keeps the
// item channel stalled until the flush ends, because each byte costs one
// registered read of the packet memory and one load of the output register,
// and the status result takes one more load.
// Reset clears the sender, receive handshake, packet count and result valid
// flag; the result data and the packet memory are not cleared and need no pass.
// When the receiver stalls, the result held in the output register stays
// unchanged, and the item channel stalls as soon as the next result has
// nowhere to go.
module parallel_handshake_frame_bridge
#(
    parameter int PACKET_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  pbfb_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output pbfb_pkg::result_t result
);

    pbfb_pkg::cmd_t  cmd;
    pbfb_pkg::stat_t stat;

    assign item_stall = !cmd.in_ready;

    pbfb_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .stat       (stat),
        .cmd        (cmd)
    );

    pbfb_dp
    #(
        .PACKET_DEPTH (PACKET_DEPTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

>>> src/pbfb_ctrl.sv
// Sequencing controller: accepts requests and steps packet flushes and status results.
module pbfb_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  pbfb_pkg::stat_t stat,
    output pbfb_pkg::cmd_t  cmd
);

    pbfb_pkg::ctrl_state_t state_reg;
    pbfb_pkg::ctrl_state_t state_next;
    logic                  accept;

    assign accept = item_valid && cmd.in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbfb_pkg::CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbfb_pkg::CTRL_IDLE:
            begin
                if (accept && stat.flush_any)
                begin
                    state_next = pbfb_pkg::CTRL_READ;
                end
            end
            pbfb_pkg::CTRL_READ:
            begin
                state_next = pbfb_pkg::CTRL_BYTE;
            end
            pbfb_pkg::CTRL_BYTE:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.idx_last ? pbfb_pkg::CTRL_STATUS : pbfb_pkg::CTRL_READ;
                end
            end
            pbfb_pkg::CTRL_STATUS:
            begin
                if (stat.out_free)
                begin
                    state_next = pbfb_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = pbfb_pkg::CTRL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            pbfb_pkg::CTRL_IDLE:
            begin
                cmd.in_ready = stat.out_free;
            end
            pbfb_pkg::CTRL_READ:
            begin
                cmd = '0;
            end
            pbfb_pkg::CTRL_BYTE:
            begin
                cmd.ld_byte = stat.out_free;
            end
            pbfb_pkg::CTRL_STATUS:
            begin
                cmd.ld_status = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/pbfb_dp.sv
// Datapath: bus sender, receive handshake, packet memory and the result register.
module pbfb_dp
#(
    parameter int PACKET_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  pbfb_pkg::item_t   item,
    input  logic              result_stall,
    output logic              result_valid,
    output pbfb_pkg::result_t result,
    input  pbfb_pkg::cmd_t    cmd,
    output pbfb_pkg::stat_t   stat
);

    localparam int CW = $clog2(PACKET_DEPTH);
    localparam logic [CW-1:0] COUNT_TOP = CW'(PACKET_DEPTH - 1);

    logic [7:0] mem [PACKET_DEPTH];

    pbfb_pkg::send_state_t send_state_reg;
    pbfb_pkg::send_state_t send_state_next;
    logic [7:0]            held_byte_reg;
    logic [7:0]            held_byte_next;
    logic                  rx_pending_reg;
    logic                  rx_pending_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  full_reg;
    logic                  full_next;
    logic                  udav_reg;
    logic                  udav_next;
    logic                  creq_reg;
    logic                  creq_next;
    logic                  drive_reg;
    logic                  drive_next;

    logic [CW-1:0]         idx_reg;
    logic [CW-1:0]         flush_len_reg;
    logic [7:0]            rd_data_reg;
    pbfb_pkg::result_t     status_reg;
    pbfb_pkg::result_t     status_next;
    logic                  result_valid_reg;
    pbfb_pkg::result_t     result_reg;
    pbfb_pkg::result_t     byte_result;

    logic                  accept;
    logic                  taken;
    logic                  flush_go;
    logic                  mem_we;

    assign accept = item_valid && cmd.in_ready;

    always_comb
    begin
        send_state_next = send_state_reg;
        held_byte_next  = held_byte_reg;
        rx_pending_next = rx_pending_reg;
        count_next      = count_reg;
        full_next       = full_reg;
        udav_next       = udav_reg;
        creq_next       = creq_reg;
        drive_next      = drive_reg;
        taken           = 1'b0;
        flush_go        = 1'b0;
        mem_we          = 1'b0;
        if (accept)
        begin
            if (rx_pending_reg)
            begin
                if (!item.partner_avail)
                begin
                    mem_we = 1'b1;
                    if (item.bus_sample == pbfb_pkg::TERMINATOR)
                    begin
                        full_next = 1'b1;
                    end
                    creq_next       = 1'b0;
                    count_next      = count_reg + 1'b1;
                    rx_pending_next = 1'b0;
                end
            end
            else
            begin
                if (full_reg && item.tx_ready)
                begin
                    flush_go   = 1'b1;
                    count_next = '0;
                    full_next  = 1'b0;
                end
                unique case (send_state_reg)
                    pbfb_pkg::SEND_IDLE:
                    begin
                        if (item.host_valid)
                        begin
                            held_byte_next  = item.host_byte;
                            taken           = 1'b1;
                            udav_next       = 1'b1;
                            send_state_next = pbfb_pkg::SEND_READY;
                        end
                    end
                    pbfb_pkg::SEND_YIELDED:
                    begin
                        send_state_next = pbfb_pkg::SEND_READY;
                    end
                    pbfb_pkg::SEND_READY:
                    begin
                        if (item.partner_ready && !item.partner_avail)
                        begin
                            drive_next      = 1'b1;
                            udav_next       = 1'b0;
                            send_state_next = pbfb_pkg::SEND_DRIVING;
                        end
                        else if (item.partner_avail)
                        begin
                            send_state_next = pbfb_pkg::SEND_YIELDED;
                        end
                    end
                    pbfb_pkg::SEND_DRIVING:
                    begin
                        if (!item.partner_ready)
                        begin
                            drive_next      = 1'b0;
                            send_state_next = pbfb_pkg::SEND_IDLE;
                        end
                    end
                    default:
                    begin
                        send_state_next = pbfb_pkg::SEND_IDLE;
                    end
                endcase
                if (send_state_next == pbfb_pkg::SEND_IDLE ||
                    send_state_next == pbfb_pkg::SEND_YIELDED)
                begin
                    if (item.partner_avail && count_next < COUNT_TOP)
                    begin
                        creq_next       = 1'b1;
                        rx_pending_next = 1'b1;
                    end
                    else if (count_next >= COUNT_TOP)
                    begin
                        full_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        status_next              = '0;
        status_next.last         = 1'b1;
        status_next.host_taken   = taken;
        status_next.udav_line    = udav_next;
        status_next.creq_line    = creq_next;
        status_next.drive_enable = drive_next;
        status_next.bus_drive    = drive_next ? held_byte_next : 8'h00;
    end

    always_comb
    begin
        byte_result          = '0;
        byte_result.kind     = 1'b1;
        byte_result.pkt_byte = rd_data_reg;
    end

    assign stat.flush_any = flush_go && (count_reg != '0);
    assign stat.out_free  = !result_valid_reg || !result_stall;
    assign stat.idx_last  = ({1'b0, idx_reg} + 1'b1) == {1'b0, flush_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_state_reg <= pbfb_pkg::SEND_IDLE;
            held_byte_reg  <= '0;
            rx_pending_reg <= 1'b0;
            count_reg      <= '0;
            full_reg       <= 1'b0;
            udav_reg       <= 1'b0;
            creq_reg       <= 1'b0;
            drive_reg      <= 1'b0;
            idx_reg        <= '0;
            flush_len_reg  <= '0;
        end
        else
        begin
            send_state_reg <= send_state_next;
            held_byte_reg  <= held_byte_next;
            rx_pending_reg <= rx_pending_next;
            count_reg      <= count_next;
            full_reg       <= full_next;
            udav_reg       <= udav_next;
            creq_reg       <= creq_next;
            drive_reg      <= drive_next;
            if (accept)
            begin
                idx_reg <= '0;
                if (flush_go)
                begin
                    flush_len_reg <= count_reg;
                end
            end
            else if (cmd.ld_byte)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg] <= item.bus_sample;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            priority if ((accept && !stat.flush_any) || cmd.ld_byte || cmd.ld_status)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (accept && !stat.flush_any)
        begin
            result_reg <= status_next;
        end
        else if (cmd.ld_byte)
        begin
            result_reg <= byte_result;
        end
        else if (cmd.ld_status)
        begin
            result_reg <= status_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> src/pbfb_checker.sv
// Port-level assertions for the bridge and the bind that attaches them.
module pbfb_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input pbfb_pkg::result_t result
);

    // A stalled result must hold until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // Only the status result closes a request's run.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.kind != result.last))
        else $error("result kind and last disagree");

    // Packet byte results carry no pin levels.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind |-> !result.host_taken && !result.udav_line &&
            !result.creq_line && !result.drive_enable && (result.bus_drive == 8'h00))
        else $error("packet byte result carries pin levels");

    // The bus is released while we ask the partner for a byte, and a released bus
    // shows no data.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.kind |->
            (!result.creq_line || !result.drive_enable) &&
            (result.drive_enable || (result.bus_drive == 8'h00)))
        else $error("bus levels inconsistent with request line");

    // A request is taken only when the output register can take its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |-> !result_valid || !result_stall)
        else $error("request accepted while the output is blocked");

endmodule

bind parallel_handshake_frame_bridge pbfb_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

>>> tb/sv/parallel_handshake_frame_bridge_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the frame bridge's results and compares them with what it returns.
module parallel_handshake_frame_bridge_checker
#(
    parameter int PACKET_DEPTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  pbfb_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  pbfb_pkg::result_t result,
    output int                errors,
    output int                outstanding
);

    pbfb_pkg::send_state_t sender;
    logic [7:0]            held_byte;
    logic                  rx_wait;
    logic [7:0]            packet_mem [PACKET_DEPTH];
    int unsigned           packet_count;
    logic                  packet_full;
    logic                  udav;
    logic                  creq;
    logic                  drive;
    pbfb_pkg::result_t     due_results [$];
    pbfb_pkg::result_t     oldest;

    initial
    begin
        errors = 0;
        outstanding = 0;
    end

    task check_field(input string label, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %h, actual %h", $time, label, want, got);
        end
    endtask

    // Applies one request to the predicted state and queues the results it causes.
    task bridge_tick(input pbfb_pkg::item_t it);
        pbfb_pkg::result_t r;
        logic              taken;
        taken = 1'b0;
        if (rx_wait)
        begin
            if (!it.partner_avail)
            begin
                if (packet_count < PACKET_DEPTH)
                    packet_mem[packet_count] = it.bus_sample;
                if (it.bus_sample == pbfb_pkg::TERMINATOR)
                    packet_full = 1'b1;
                creq = 1'b0;
                if (packet_count < PACKET_DEPTH)
                    packet_count++;
                rx_wait = 1'b0;
            end
        end
        else
        begin
            if (packet_full && it.tx_ready)
            begin
                for (int k = 0; k < packet_count && k < PACKET_DEPTH - 1; k++)
                begin
                    r = '0;
                    r.kind = 1'b1;
                    r.pkt_byte = packet_mem[k];
                    due_results.push_back(r);
                end
                packet_count = 0;
                packet_full = 1'b0;
            end
            case (sender)
                pbfb_pkg::SEND_IDLE:
                begin
                    if (it.host_valid)
                    begin
                        held_byte = it.host_byte;
                        taken = 1'b1;
                        udav = 1'b1;
                        sender = pbfb_pkg::SEND_READY;
                    end
                end
                pbfb_pkg::SEND_YIELDED:
                begin
                    sender = pbfb_pkg::SEND_READY;
                end
                pbfb_pkg::SEND_READY:
                begin
                    if (it.partner_ready && !it.partner_avail)
                    begin
                        drive = 1'b1;
                        udav = 1'b0;
                        sender = pbfb_pkg::SEND_DRIVING;
                    end
                    else if (it.partner_avail)
                    begin
                        sender = pbfb_pkg::SEND_YIELDED;
                    end
                end
                default:
                begin
                    if (!it.partner_ready)
                    begin
                        drive = 1'b0;
                        sender = pbfb_pkg::SEND_IDLE;
                    end
                end
            endcase
            if (sender == pbfb_pkg::SEND_IDLE || sender == pbfb_pkg::SEND_YIELDED)
            begin
                if (it.partner_avail && packet_count < PACKET_DEPTH - 1)
                begin
                    creq = 1'b1;
                    rx_wait = 1'b1;
                end
                else if (packet_count >= PACKET_DEPTH - 1)
                begin
                    packet_full = 1'b1;
                end
            end
        end
        r = '0;
        r.last = 1'b1;
        r.host_taken = taken;
        r.udav_line = udav;
        r.creq_line = creq;
        r.drive_enable = drive;
        r.bus_drive = drive ? held_byte : 8'h00;
        due_results.push_back(r);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sender = pbfb_pkg::SEND_IDLE;
            held_byte = 8'h00;
            rx_wait = 1'b0;
            packet_count = 0;
            packet_full = 1'b0;
            udav = 1'b0;
            creq = 1'b0;
            drive = 1'b0;
            due_results.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result expected none, actual %h", $time, result);
                end
                else
                begin
                    oldest = due_results.pop_front();
                    check_field("kind", 8'(oldest.kind), 8'(result.kind));
                    check_field("pkt_byte", oldest.pkt_byte, result.pkt_byte);
                    check_field("last", 8'(oldest.last), 8'(result.last));
                    check_field("host_taken", 8'(oldest.host_taken),
                                8'(result.host_taken));
                    check_field("udav_line", 8'(oldest.udav_line), 8'(result.udav_line));
                    check_field("creq_line", 8'(oldest.creq_line), 8'(result.creq_line));
                    check_field("drive_enable", 8'(oldest.drive_enable),
                                8'(result.drive_enable));
                    check_field("bus_drive", oldest.bus_drive, result.bus_drive);
                end
            end
            if (item_valid && !item_stall)
                bridge_tick(item);
        end
        outstanding <= due_results.size();
    end

endmodule

>>> tb/sv/parallel_handshake_frame_bridge_test.sv
`timescale 1ns / 100ps
// Top of the frame bridge testbench: clock, reset, request stimulus and the verdict.
module parallel_handshake_frame_bridge_test;

    localparam int PACKET_DEPTH = 64;
    localparam int RANDOM_ITEMS = 380;
    localparam int CYCLE_LIMIT = 600000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    pbfb_pkg::item_t   item = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    pbfb_pkg::result_t result;
    int                errors;
    int                outstanding;
    logic              calm = 1'b0;
    int                cycles = 0;
    int                bytes_left = 0;
    int                avail_hold = 0;
    logic              ends_with_term = 1'b0;
    logic              ready_level = 1'b0;

    parallel_handshake_frame_bridge #(
        .PACKET_DEPTH (PACKET_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    parallel_handshake_frame_bridge_checker #(
        .PACKET_DEPTH (PACKET_DEPTH)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_stall <= !calm && ($urandom_range(99) < 20);
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("parallel_handshake_frame_bridge: mismatch");
            $finish;
        end
    end

    function pbfb_pkg::item_t pins(input logic hv, input logic [7:0] hb, input logic pr,
                                   input logic pa, input logic [7:0] bus, input logic txr);
        pbfb_pkg::item_t it;
        it.host_valid = hv;
        it.host_byte = hb;
        it.partner_ready = pr;
        it.partner_avail = pa;
        it.bus_sample = bus;
        it.tx_ready = txr;
        return it;
    endfunction

    task send_tick(input pbfb_pkg::item_t it);
        while (!calm && $urandom_range(99) < 20)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task wait_drained;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Partner packets are mostly well formed: data available high, then low with the byte.
    task random_tick;
        pbfb_pkg::item_t it;
        it = pins(1'($urandom_range(1)), 8'($urandom), ready_level, 1'b0, 8'($urandom),
                  $urandom_range(99) < 70);
        if ($urandom_range(99) < 30)
            ready_level = !ready_level;
        if (bytes_left == 0)
        begin
            if ($urandom_range(99) < 25)
            begin
                if ($urandom_range(99) < 85)
                begin
                    bytes_left = $urandom_range(8, 1);
                    ends_with_term = 1'b1;
                end
                else
                begin
                    bytes_left = $urandom_range(80, 60);
                    ends_with_term = 1'($urandom_range(1));
                end
                avail_hold = $urandom_range(2, 1);
            end
            else if ($urandom_range(99) < 10)
            begin
                it.partner_avail = 1'b1;
            end
        end
        else if (avail_hold > 0)
        begin
            it.partner_avail = 1'b1;
            avail_hold--;
        end
        else
        begin
            if (bytes_left == 1 && ends_with_term)
                it.bus_sample = pbfb_pkg::TERMINATOR;
            bytes_left--;
            avail_hold = $urandom_range(2, 1);
        end
        send_tick(it);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
        send_tick(pins(1'b1, 8'hFF, 1'b0, 1'b0, 8'hFF, 1'b0));
        send_tick(pins(1'b1, 8'hAA, 1'b1, 1'b0, 8'h00, 1'b0));
        send_tick(pins(1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
        send_tick(pins(1'b1, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0));
        // The partner wins the bus even though it is also ready to take our byte.
        send_tick(pins(1'b0, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0));
        send_tick(pins(1'b1, 8'h55, 1'b1, 1'b1, 8'h00, 1'b1));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b0, pbfb_pkg::TERMINATOR, 1'b1));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b0, 8'hFF, 1'b0));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1));
        send_tick(pins(1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b0, 8'h80, 1'b0));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0));
        send_tick(pins(1'b0, 8'h00, 1'b0, 1'b0, pbfb_pkg::TERMINATOR, 1'b1));
        send_tick(pins(1'b1, 8'h01, 1'b0, 1'b0, 8'h00, 1'b1));
        item_valid <= 1'b0;
        wait_drained;

        // The first random packet has no terminator and overfills the packet store.
        bytes_left = 75;
        ends_with_term = 1'b0;
        avail_hold = 1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm <= (n >= 100 && n < 180);
            if (n == 240)
            begin
                item_valid <= 1'b0;
                wait_drained;
            end
            random_tick();
        end
        item_valid <= 1'b0;
        wait_drained;
        repeat (2 * PACKET_DEPTH + 10) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("parallel_handshake_frame_bridge: match");
        else
            $display("parallel_handshake_frame_bridge: mismatch");
        $finish;
    end

endmodule
